// File: hdl/ordered_list_engine_unit_assert.svh
// assertion macros for the ordered list engine
// included by files that carry concurrent checks; expects clk and arst_n in scope
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OLE_ASSERT_NOW(label, ante, cons, msg)
`define OLE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hdl/ole_pkg.sv
// shared types and codes for the ordered list engine
// no dependencies; used by the controller, datapath and top level
package ole_pkg;

	// request codes
	localparam logic [3:0] OP_INS_FRONT  = 4'd0;
	localparam logic [3:0] OP_INS_BACK   = 4'd1;
	localparam logic [3:0] OP_INS_POS    = 4'd2;
	localparam logic [3:0] OP_INS_BEFORE = 4'd3;
	localparam logic [3:0] OP_INS_AFTER  = 4'd4;
	localparam logic [3:0] OP_DEL_FRONT  = 4'd5;
	localparam logic [3:0] OP_DEL_BACK   = 4'd6;
	localparam logic [3:0] OP_DEL_POS    = 4'd7;
	localparam logic [3:0] OP_DEL_KEY    = 4'd8;
	localparam logic [3:0] OP_SEARCH     = 4'd9;

	// status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_NOKEY  = 3'd2;
	localparam logic [2:0] ST_BADPOS = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_UP,
		S_PUT,
		S_SHIFT_DN
	} state_t;

	// walk index updates
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_COUNT,
		IDX_TGT_P1,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	// sources for the target index
	typedef enum logic [2:0] {
		TGT_ZERO,
		TGT_COUNT,
		TGT_COUNT_M1,
		TGT_POS,
		TGT_HIT,
		TGT_HIT_P1
	} tgt_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       load_req;
		idx_op_t    idx_op;
		logic       tgt_ld;
		tgt_sel_t   tgt_sel;
		logic       rd;
		logic       rd_prev;
		logic       wr_shift;
		logic       shift_up;
		logic       wr_put;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_valid;
		logic [2:0] res_status;
		logic       res_found;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic pos_ins_ok;
		logic pos_del_ok;
		logic idx_at_count;
		logic idx_at_tgt;
		logic hit;
	} flags_t;

endpackage

// File: hdl/ole_ctrl.sv
// controller state machine for the ordered list engine
// depends on ole_pkg for codes, states and the command/flag structs
module ole_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [3:0]       req_type,
	input  ole_pkg::flags_t  flags,
	output logic             busy,
	output ole_pkg::cmd_t    cmd
);

	ole_pkg::state_t state_q, state_next;
	logic [3:0]      op_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ole_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// request code held for the scan decision
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q <= req_type;
		end
	end

	assign busy = (state_q != ole_pkg::S_IDLE);

	// next state and commands
	always_comb begin
		state_next     = state_q;
		cmd            = '0;
		cmd.idx_op     = ole_pkg::IDX_HOLD;
		cmd.tgt_sel    = ole_pkg::TGT_ZERO;
		cmd.res_status = ole_pkg::ST_OK;
		unique case (state_q)
			ole_pkg::S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					unique case (req_type)
						ole_pkg::OP_INS_FRONT,
						ole_pkg::OP_INS_BACK: begin
							if (flags.cnt_full) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_FULL;
							end else begin
								cmd.tgt_ld  = 1'b1;
								cmd.tgt_sel = (req_type == ole_pkg::OP_INS_FRONT) ?
									ole_pkg::TGT_ZERO : ole_pkg::TGT_COUNT;
								cmd.idx_op  = ole_pkg::IDX_COUNT;
								state_next  = ole_pkg::S_SHIFT_UP;
							end
						end
						ole_pkg::OP_INS_POS: begin
							priority if (flags.cnt_full) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_FULL;
							end else if (flags.pos_ins_ok) begin
								cmd.tgt_ld  = 1'b1;
								cmd.tgt_sel = ole_pkg::TGT_POS;
								cmd.idx_op  = ole_pkg::IDX_COUNT;
								state_next  = ole_pkg::S_SHIFT_UP;
							end else begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = flags.cnt_zero ?
									ole_pkg::ST_EMPTY : ole_pkg::ST_BADPOS;
							end
						end
						ole_pkg::OP_INS_BEFORE,
						ole_pkg::OP_INS_AFTER: begin
							priority if (flags.cnt_full) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_FULL;
							end else if (flags.cnt_zero) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_EMPTY;
							end else begin
								cmd.idx_op = ole_pkg::IDX_ZERO;
								state_next = ole_pkg::S_SCAN;
							end
						end
						ole_pkg::OP_DEL_FRONT,
						ole_pkg::OP_DEL_BACK: begin
							if (flags.cnt_zero) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_EMPTY;
							end else begin
								cmd.tgt_ld  = 1'b1;
								cmd.tgt_sel = (req_type == ole_pkg::OP_DEL_FRONT) ?
									ole_pkg::TGT_ZERO : ole_pkg::TGT_COUNT_M1;
								cmd.idx_op  = ole_pkg::IDX_TGT_P1;
								state_next  = ole_pkg::S_SHIFT_DN;
							end
						end
						ole_pkg::OP_DEL_POS: begin
							priority if (flags.cnt_zero) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_EMPTY;
							end else if (flags.pos_del_ok) begin
								cmd.tgt_ld  = 1'b1;
								cmd.tgt_sel = ole_pkg::TGT_POS;
								cmd.idx_op  = ole_pkg::IDX_TGT_P1;
								state_next  = ole_pkg::S_SHIFT_DN;
							end else begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_BADPOS;
							end
						end
						ole_pkg::OP_DEL_KEY,
						ole_pkg::OP_SEARCH: begin
							if (flags.cnt_zero) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ole_pkg::ST_EMPTY;
							end else begin
								cmd.idx_op = ole_pkg::IDX_ZERO;
								state_next = ole_pkg::S_SCAN;
							end
						end
						default: begin
							// unused codes finish at once with ok
							cmd.res_valid = 1'b1;
						end
					endcase
				end
			end
			ole_pkg::S_SCAN: begin
				// first match from the front ends the walk
				priority if (flags.hit) begin
					unique case (op_q)
						ole_pkg::OP_INS_BEFORE: begin
							cmd.tgt_ld  = 1'b1;
							cmd.tgt_sel = ole_pkg::TGT_HIT;
							cmd.idx_op  = ole_pkg::IDX_COUNT;
							state_next  = ole_pkg::S_SHIFT_UP;
						end
						ole_pkg::OP_INS_AFTER: begin
							cmd.tgt_ld  = 1'b1;
							cmd.tgt_sel = ole_pkg::TGT_HIT_P1;
							cmd.idx_op  = ole_pkg::IDX_COUNT;
							state_next  = ole_pkg::S_SHIFT_UP;
						end
						ole_pkg::OP_DEL_KEY: begin
							cmd.tgt_ld  = 1'b1;
							cmd.tgt_sel = ole_pkg::TGT_HIT;
							cmd.idx_op  = ole_pkg::IDX_TGT_P1;
							state_next  = ole_pkg::S_SHIFT_DN;
						end
						default: begin
							cmd.res_valid = 1'b1;
							cmd.res_found = 1'b1;
							state_next    = ole_pkg::S_IDLE;
						end
					endcase
				end else if (flags.idx_at_count) begin
					cmd.res_valid  = 1'b1;
					cmd.res_status = ole_pkg::ST_NOKEY;
					state_next     = ole_pkg::S_IDLE;
				end else begin
					cmd.rd     = 1'b1;
					cmd.idx_op = ole_pkg::IDX_INC;
				end
			end
			ole_pkg::S_SHIFT_UP: begin
				// move entries up one slot, from the tail down to the target
				cmd.wr_shift = 1'b1;
				cmd.shift_up = 1'b1;
				if (flags.idx_at_tgt) begin
					state_next = ole_pkg::S_PUT;
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_prev = 1'b1;
					cmd.idx_op  = ole_pkg::IDX_DEC;
				end
			end
			ole_pkg::S_PUT: begin
				cmd.wr_put    = 1'b1;
				cmd.cnt_inc   = 1'b1;
				cmd.res_valid = 1'b1;
				state_next    = ole_pkg::S_IDLE;
			end
			ole_pkg::S_SHIFT_DN: begin
				// move entries down one slot, from past the target to the tail
				cmd.wr_shift = 1'b1;
				if (flags.idx_at_count) begin
					cmd.cnt_dec   = 1'b1;
					cmd.res_valid = 1'b1;
					state_next    = ole_pkg::S_IDLE;
				end else begin
					cmd.rd     = 1'b1;
					cmd.idx_op = ole_pkg::IDX_INC;
				end
			end
			default: begin
				state_next = ole_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/ole_datapath.sv
// datapath for the ordered list engine: entry memory, count, walk index, results
// depends on ole_pkg for the command/flag structs and status codes
module ole_datapath #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ole_pkg::cmd_t       cmd,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  match_key,
	input  logic [6:0]          position,
	output ole_pkg::flags_t     flags,
	output logic                done,
	output logic [2:0]          status,
	output logic [6:0]          found_position,
	output logic [6:0]          entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = ((CW > 7) ? CW : 7) + 1;

	logic signed [31:0] mem [CAPACITY];

	logic [CW-1:0]      count_q, idx_q, tgt_q;
	logic [CW-1:0]      tgt_next, rd_addr, wr_idx, rd_idx_s1;
	logic               rdv_s1;
	logic signed [31:0] rd_s1, key_q, val_q, wr_data;
	logic               wr_en;
	logic [EW-1:0]      pos_ext, cnt_ext;
	logic               done_q;
	logic [2:0]         status_q;
	logic [6:0]         found_q;

	// status flags for the controller
	always_comb begin
		pos_ext            = EW'(position);
		cnt_ext            = EW'(count_q);
		flags.cnt_zero     = (count_q == '0);
		flags.cnt_full     = (count_q == CW'(CAPACITY));
		flags.pos_ins_ok   = (position != '0) && (pos_ext <= cnt_ext + EW'(1));
		flags.pos_del_ok   = (position != '0) && (pos_ext <= cnt_ext);
		flags.idx_at_count = (idx_q == count_q);
		flags.idx_at_tgt   = (idx_q == tgt_q);
		flags.hit          = rdv_s1 && (rd_s1 == key_q);
	end

	// target index source
	always_comb begin
		unique case (cmd.tgt_sel)
			ole_pkg::TGT_ZERO:     tgt_next = '0;
			ole_pkg::TGT_COUNT:    tgt_next = count_q;
			ole_pkg::TGT_COUNT_M1: tgt_next = count_q - CW'(1);
			ole_pkg::TGT_POS:      tgt_next = CW'(pos_ext - EW'(1));
			ole_pkg::TGT_HIT:      tgt_next = rd_idx_s1;
			ole_pkg::TGT_HIT_P1:   tgt_next = rd_idx_s1 + CW'(1);
			default:               tgt_next = '0;
		endcase
	end

	// memory port addressing
	always_comb begin
		rd_addr = cmd.rd_prev ? (idx_q - CW'(1)) : idx_q;
		wr_en   = cmd.wr_put || (cmd.wr_shift && rdv_s1);
		priority if (cmd.wr_put) begin
			wr_idx  = tgt_q;
			wr_data = val_q;
		end else if (cmd.shift_up) begin
			wr_idx  = rd_idx_s1 + CW'(1);
			wr_data = rd_s1;
		end else begin
			wr_idx  = rd_idx_s1 - CW'(1);
			wr_data = rd_s1;
		end
	end

	// entry memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[AW-1:0]] <= wr_data;
		end
		if (cmd.rd) begin
			rd_s1 <= mem[rd_addr[AW-1:0]];
		end
	end

	// request operands, target and read index
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q <= match_key;
			val_q <= value;
		end
		if (cmd.tgt_ld) begin
			tgt_q <= tgt_next;
		end
		if (cmd.rd) begin
			rd_idx_s1 <= rd_addr;
		end
		if (cmd.res_valid) begin
			status_q <= cmd.res_status;
			found_q  <= cmd.res_found ? 7'(rd_idx_s1 + CW'(1)) : 7'd0;
		end
	end

	// count, walk index, read valid and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			rdv_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			rdv_s1 <= cmd.rd;
			done_q <= cmd.res_valid;
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			unique case (cmd.idx_op)
				ole_pkg::IDX_HOLD:   idx_q <= idx_q;
				ole_pkg::IDX_ZERO:   idx_q <= '0;
				ole_pkg::IDX_COUNT:  idx_q <= count_q;
				ole_pkg::IDX_TGT_P1: idx_q <= tgt_next + CW'(1);
				ole_pkg::IDX_INC:    idx_q <= idx_q + CW'(1);
				ole_pkg::IDX_DEC:    idx_q <= idx_q - CW'(1);
				default:             idx_q <= idx_q;
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign entry_count    = 7'(count_q);

endmodule

// File: hdl/ordered_list_engine_unit.sv
// top level of the ordered list engine: controller plus datapath
// depends on ole_pkg, ole_ctrl, ole_datapath and the assertion macro header
//
// Ordered list of up to CAPACITY signed 32-bit values. A request is taken when
// start is high and busy is low. Its single result appears on status,
// found_position and entry_count for exactly one cycle with done high. It must
// be captured then, since it cannot be held off. A request that is refused or
// needs no walk (bad position, empty, full, unused code) has its result
// registered on the accepting edge. Otherwise the entry memory, with one read
// and one write port, is walked one entry per cycle. An insert shifts entries
// from the tail down to its target up one slot and then writes the value; a
// delete shifts entries past its target down one slot; a key search walks from
// the front to the first match. Insert or delete by key shifts only from the
// match onward. Insert before a key is the slowest case. busy stays low while
// done is shown, so the next request may be issued in the same cycle as the
// result. No memory clearing pass is needed after reset; entries above the count
// are never read.
`include "ordered_list_engine_unit_assert.svh"

module ordered_list_engine_unit #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         req_type,
	input  logic signed [31:0] value,
	input  logic signed [31:0] match_key,
	input  logic [6:0]         position,
	output logic               done,
	output logic [2:0]         status,
	output logic [6:0]         found_position,
	output logic [6:0]         entry_count
);

	ole_pkg::cmd_t   cmd;
	ole_pkg::flags_t flags;

	// sequencing
	ole_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.flags    (flags),
		.busy     (busy),
		.cmd      (cmd)
	);

	// storage and result registers
	ole_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.value          (value),
		.match_key      (match_key),
		.position       (position),
		.flags          (flags),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	// every accepted request either starts a walk or finishes at once
	`OLE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "request dropped")
	// a result is only shown once the controller is idle again
	`OLE_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
	// a reported match position comes with an ok status
	`OLE_ASSERT_NOW(a_found_ok, done && (found_position != 7'd0), status == ole_pkg::ST_OK, "bad found")
	// the count changes only with a result
	`OLE_ASSERT_NOW(a_count_on_done, !$stable(entry_count), done, "count moved without result")

endmodule
